### src/epc_pkg.sv
// ----------------------------------------------------------------------------
// epc_pkg
// shared constants, types and bus layout of the edge partition classifier
// ----------------------------------------------------------------------------
package epc_pkg;

  localparam int NUM_PARTS   = 16;
  localparam int NODE_BITS   = 32;
  localparam int IN_W        = 32;
  localparam int ID_W        = (NODE_BITS < IN_W) ? NODE_BITS : IN_W;
  localparam int UP_W        = IN_W + 1;
  localparam int IDX_W       = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam int CNT_W       = $clog2(NUM_PARTS + 1);
  localparam int SLOT_W      = 4;
  localparam int PART_W      = 4;
  localparam int DIST_W      = 5;
  localparam int NEIGH_W     = 16;
  localparam int TOT_W       = 48;
  localparam int NPARTS_W    = 5;
  localparam int LOCAL_W     = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // slave tdata layout
  localparam int S_SLOT_LSB  = 0;
  localparam int S_LO_LSB    = S_SLOT_LSB + SLOT_W;
  localparam int S_CNT_LSB   = S_LO_LSB + IN_W;
  localparam int S_ID_LSB    = S_CNT_LSB + IN_W;
  localparam int S_USED_W    = S_ID_LSB + IN_W;
  localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

  // master tdata layout
  localparam int M_USED_W    = PART_W + DIST_W + NEIGH_W + 1 + 4 * TOT_W;
  localparam int M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;
  localparam int M_PAD_W     = M_TDATA_W - M_USED_W;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_PARTS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_PART = 1'b1;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_EDGE = 2'd1,
    MODE_EOR  = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef struct packed {
    logic             eor;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic valid;
    logic full;
    cmd_t cmd;
  } q_stat_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } back_stat_t;

endpackage

### src/epc_front.sv
// ----------------------------------------------------------------------------
// epc_front
// takes beats, keeps the range table and classifies neighbor ids
// ----------------------------------------------------------------------------
module epc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [1:0]                     s_mode_i,
  input  logic [epc_pkg::S_TDATA_W-1:0]  s_data_i,
  input  logic [epc_pkg::NPARTS_W-1:0]   num_parts_i,
  input  logic                           q_full_i,
  output epc_pkg::push_t                 push_o
);
  import epc_pkg::*;

  logic              st_valid_q;
  mode_e             st_mode_q;
  logic [SLOT_W-1:0] st_slot_q;
  logic [ID_W-1:0]   st_lo_q;
  logic [IN_W-1:0]   st_cnt_q;
  logic [ID_W-1:0]   st_id_q;

  logic [NUM_PARTS-1:0] tab_valid_q;
  logic [ID_W-1:0]      tab_lower_q [NUM_PARTS];
  logic [UP_W-1:0]      tab_upper_q [NUM_PARTS];

  logic                 needs_push;
  logic                 done;
  logic                 accept;
  logic                 slot_ok;
  logic                 load_en;
  logic [7:0]           slot_ext;
  logic [IDX_W-1:0]     wr_idx;
  logic [NUM_PARTS-1:0] match;
  logic [IDX_W-1:0]     hit_idx;

  assign needs_push = (st_mode_q == MODE_EDGE) || (st_mode_q == MODE_EOR);
  assign done       = st_valid_q && (!needs_push || !q_full_i);
  assign s_tready_o = !st_valid_q || done;
  assign accept     = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (accept) begin
      st_valid_q <= 1'b1;
    end else if (done) begin
      st_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_mode_q <= mode_e'(s_mode_i);
      st_slot_q <= s_data_i[S_SLOT_LSB +: SLOT_W];
      st_lo_q   <= s_data_i[S_LO_LSB +: ID_W];
      st_cnt_q  <= s_data_i[S_CNT_LSB +: IN_W];
      st_id_q   <= s_data_i[S_ID_LSB +: ID_W];
    end
  end

  // range table writes
  assign slot_ok  = int'(st_slot_q) < NUM_PARTS;
  assign slot_ext = 8'(st_slot_q);
  assign wr_idx   = slot_ext[IDX_W-1:0];
  assign load_en  = done && (st_mode_q == MODE_LOAD) && slot_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_valid_q <= '0;
    end else if (load_en) begin
      tab_valid_q[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      tab_lower_q[wr_idx] <= st_lo_q;
      tab_upper_q[wr_idx] <= UP_W'(st_lo_q) + UP_W'(st_cnt_q);
    end
  end

  // parallel range compare, lowest slot wins
  always_comb begin
    for (int i = 0; i < NUM_PARTS; i++) begin
      match[i] = tab_valid_q[i] && (i < int'(num_parts_i)) &&
                 (tab_lower_q[i] <= st_id_q) && (UP_W'(st_id_q) < tab_upper_q[i]);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = NUM_PARTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign push_o.push    = done && needs_push;
  assign push_o.cmd.eor = (st_mode_q == MODE_EOR);
  assign push_o.cmd.hit = (st_mode_q == MODE_EDGE) && (|match);
  assign push_o.cmd.idx = hit_idx;

endmodule

### src/epc_queue.sv
// ----------------------------------------------------------------------------
// epc_queue
// short command queue between the classifier front and the row back end
// ----------------------------------------------------------------------------
module epc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  epc_pkg::push_t   push_i,
  input  logic             pop_i,
  output epc_pkg::q_stat_t stat_o
);
  import epc_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q;
  logic [QPTR_W-1:0] rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push;
  logic              do_pop;

  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.cmd   = mem_q[rptr_q];

  assign do_push = push_i.push && !stat_o.full;
  assign do_pop  = pop_i && stat_o.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_i.cmd;
    end
  end

endmodule

### src/epc_back.sv
// ----------------------------------------------------------------------------
// epc_back
// row set, counters and totals; emits one beat for an empty set, else one result beat per set entry
// ----------------------------------------------------------------------------
module epc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  epc_pkg::q_stat_t              q_i,
  output logic                          pop_o,
  input  logic [epc_pkg::LOCAL_W-1:0]   local_part_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [epc_pkg::M_TDATA_W-1:0] m_tdata_o,
  output logic                          m_tlast_o,
  output epc_pkg::back_stat_t           stat_o
);
  import epc_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  function automatic logic [TOT_W-1:0] sat_add(logic [TOT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [TOT_W:0] sum;
    sum = {1'b0, a} + (TOT_W + 1)'(b);
    return sum[TOT_W] ? {TOT_W{1'b1}} : sum[TOT_W-1:0];
  endfunction

  state_e               state_q;
  logic [NUM_PARTS-1:0] row_set_q;
  logic [CNT_W-1:0]     row_cnt_q;
  logic [NEIGH_W-1:0]   row_neigh_q;
  logic                 row_cross_q;
  logic [TOT_W-1:0]     tot_ce_q;
  logic [TOT_W-1:0]     tot_cr_q;
  logic [TOT_W-1:0]     tot_re_q;
  logic [TOT_W-1:0]     tot_e_q;

  logic [NUM_PARTS-1:0] emit_mask_q;
  logic [CNT_W-1:0]     emit_cnt_q;
  logic [NEIGH_W-1:0]   emit_neigh_q;
  logic                 emit_cross_q;

  logic                 m_valid_q;
  logic [PART_W-1:0]    o_part_q;
  logic [DIST_W-1:0]    o_dist_q;
  logic [NEIGH_W-1:0]   o_neigh_q;
  logic                 o_cross_q;
  logic                 o_last_q;
  logic [TOT_W-1:0]     o_ce_q;
  logic [TOT_W-1:0]     o_cr_q;
  logic [TOT_W-1:0]     o_re_q;
  logic [TOT_W-1:0]     o_e_q;

  logic                 local_in_set;
  logic [CNT_W-1:0]     remote;
  logic                 is_cross;
  logic                 out_free;
  logic [IDX_W-1:0]     nxt_idx;
  logic [7:0]           nxt_ext;
  logic [NUM_PARTS-1:0] low_bit;
  logic [NUM_PARTS-1:0] rest_mask;

  assign pop_o = (state_q == ST_IDLE) && q_i.valid;

  always_comb begin
    local_in_set = 1'b0;
    for (int i = 0; i < NUM_PARTS; i++) begin
      if (i == int'(local_part_i)) begin
        local_in_set = row_set_q[i];
      end
    end
  end

  assign remote   = row_cnt_q - CNT_W'(local_in_set);
  assign is_cross = q_i.cmd.hit && (int'(q_i.cmd.idx) != int'(local_part_i));
  assign out_free = !m_valid_q || m_tready_i;

  // lowest remaining entry of the set
  always_comb begin
    nxt_idx = '0;
    for (int i = NUM_PARTS - 1; i >= 0; i--) begin
      if (emit_mask_q[i]) begin
        nxt_idx = IDX_W'(i);
      end
    end
  end

  assign nxt_ext   = 8'(nxt_idx);
  assign low_bit   = emit_mask_q & (~emit_mask_q + 1'b1);
  assign rest_mask = emit_mask_q & ~low_bit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      row_set_q    <= '0;
      row_cnt_q    <= '0;
      row_neigh_q  <= '0;
      row_cross_q  <= 1'b0;
      tot_ce_q     <= '0;
      tot_cr_q     <= '0;
      tot_re_q     <= '0;
      tot_e_q      <= '0;
      emit_mask_q  <= '0;
      emit_cnt_q   <= '0;
      emit_neigh_q <= '0;
      emit_cross_q <= 1'b0;
      m_valid_q    <= 1'b0;
      o_part_q     <= '0;
      o_dist_q     <= '0;
      o_neigh_q    <= '0;
      o_cross_q    <= 1'b0;
      o_last_q     <= 1'b0;
      o_ce_q       <= '0;
      o_cr_q       <= '0;
      o_re_q       <= '0;
      o_e_q        <= '0;
    end else begin
      if (m_tready_i && (state_q != ST_EMIT)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o && q_i.cmd.eor) begin
            if (row_cross_q) begin
              tot_cr_q <= sat_add(tot_cr_q, CNT_W'(1));
            end
            tot_e_q      <= sat_add(tot_e_q, row_cnt_q);
            tot_re_q     <= sat_add(tot_re_q, remote);
            emit_mask_q  <= row_set_q;
            emit_cnt_q   <= row_cnt_q;
            emit_neigh_q <= row_neigh_q;
            emit_cross_q <= row_cross_q;
            row_set_q    <= '0;
            row_cnt_q    <= '0;
            row_neigh_q  <= '0;
            row_cross_q  <= 1'b0;
            state_q      <= ST_EMIT;
          end else if (pop_o) begin
            if (row_neigh_q != {NEIGH_W{1'b1}}) begin
              row_neigh_q <= row_neigh_q + 1'b1;
            end
            if (q_i.cmd.hit && !row_set_q[q_i.cmd.idx]) begin
              row_set_q[q_i.cmd.idx] <= 1'b1;
              row_cnt_q              <= row_cnt_q + 1'b1;
            end
            if (is_cross) begin
              tot_ce_q    <= sat_add(tot_ce_q, CNT_W'(1));
              row_cross_q <= 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_valid_q   <= 1'b1;
            o_dist_q    <= DIST_W'(emit_cnt_q);
            o_neigh_q   <= emit_neigh_q;
            o_cross_q   <= emit_cross_q;
            o_ce_q      <= tot_ce_q;
            o_cr_q      <= tot_cr_q;
            o_re_q      <= tot_re_q;
            o_e_q       <= tot_e_q;
            emit_mask_q <= rest_mask;
            if (emit_cnt_q == '0) begin
              o_part_q <= '0;
              o_last_q <= 1'b1;
              state_q  <= ST_IDLE;
            end else begin
              o_part_q <= nxt_ext[PART_W-1:0];
              o_last_q <= (rest_mask == '0);
              if (rest_mask == '0) begin
                state_q <= ST_IDLE;
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tlast_o  = o_last_q;
  assign m_tdata_o  = {{M_PAD_W{1'b0}}, o_e_q, o_re_q, o_cr_q, o_ce_q,
                       o_cross_q, o_neigh_q, o_dist_q, o_part_q};

  assign stat_o.busy = (state_q == ST_EMIT);
  assign stat_o.pop  = pop_o;

endmodule

### src/edge_partition_classifier_unit.sv
// ----------------------------------------------------------------------------
// edge_partition_classifier_unit
// an end-of-row beat passes the front staging register, command queue, back end
//   emit state and output register; then one result beat per cycle for each set
//   entry (one for an empty set) while not stalled, holding the back end; front
//   takes one beat per cycle, edge and end-of-row beats only if the queue has room
// reset: range table empty, row state and totals zero, num_parts 1, local 0
// ----------------------------------------------------------------------------
module edge_partition_classifier_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [epc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [epc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // slot, range_low, range_count, node_id
  input  logic [epc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // mode
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // part_index, distinct_count, neighbor_count, row_crosses, total_cross_edges,
  // total_crossing_rows, total_remote_entries, total_entries
  output logic [epc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  output logic                             m_axis_tlast
);
  import epc_pkg::*;

  logic [NPARTS_W-1:0] num_parts_q;
  logic [LOCAL_W-1:0]  local_part_q;
  push_t               push;
  q_stat_t             qstat;
  logic                pop;
  back_stat_t          bstat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_parts_q  <= NPARTS_W'(1);
      local_part_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NUM_PARTS:  num_parts_q  <= cfg_wdata_i[NPARTS_W-1:0];
        REG_LOCAL_PART: local_part_q <= cfg_wdata_i[LOCAL_W-1:0];
        default:        ;
      endcase
    end
  end

  epc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_mode_i    (s_axis_tuser),
    .s_data_i    (s_axis_tdata),
    .num_parts_i (num_parts_q),
    .q_full_i    (qstat.full),
    .push_o      (push)
  );

  epc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .stat_o (qstat)
  );

  epc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_i          (qstat),
    .pop_o        (pop),
    .local_part_i (local_part_q),
    .m_tvalid_o   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_o    (m_axis_tdata),
    .m_tlast_o    (m_axis_tlast),
    .stat_o       (bstat)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push |-> !qstat.full)
    else $error("command queue overflow");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.busy |-> !bstat.pop)
    else $error("queue popped while emitting a row");

  a_idle_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qstat.valid && !bstat.busy) |-> bstat.pop)
    else $error("back end idle with queued command");

  a_empty_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[8:4] == 5'd0)) |->
      (m_axis_tlast && (m_axis_tdata[3:0] == 4'd0)))
    else $error("empty row beat malformed");

endmodule
